### hw/rtl/upd_pkg.sv
// shared types, character constants and hex digit helper for the url percent decoder
// no dependencies
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } enc_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } dec_item_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // results produced by one accepted transaction
  typedef struct packed {
    logic [1:0] count;
    dec_item_t  first;
    dec_item_t  second;
  } dec_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      h.ok = 1'b1;
      h.value = d[3:0];
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = c - CH_UPPER_A + 8'd10;
      h.ok = 1'b1;
      h.value = d[3:0];
    end
    return h;
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/upd_decode.sv
// escape tracking state and per-byte decode logic
// depends on upd_pkg
`default_nettype none

module upd_decode (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    accept,
  input  wire upd_pkg::enc_item_t item,
  output upd_pkg::dec_result_t   result
);
  import upd_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] first_digit, first_digit_next;
  hex_t       hi, lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      first_digit <= '0;
    end else if (accept) begin
      phase <= phase_next;
      first_digit <= first_digit_next;
    end
  end

  always_comb begin
    hi = hex_value(first_digit);
    lo = hex_value(item.in_byte);
    phase_next = PH_IDLE;
    first_digit_next = first_digit;
    result = '0;
    case (phase)
      PH_PCT: begin
        if (item.in_last) begin
          // escape cut short: raw percent then the byte as ordinary
          result.count = 2'd2;
          result.first.out_byte = CH_PERCENT;
          result.first.out_last = 1'b0;
          result.second.out_byte = plain_byte(item.in_byte);
          result.second.out_last = 1'b1;
        end else begin
          first_digit_next = item.in_byte;
          phase_next = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        result.count = 2'd1;
        result.first.out_last = item.in_last;
        if (!hi.ok) begin
          result.first.out_byte = 8'h00;
        end else if (!lo.ok) begin
          result.first.out_byte = {4'h0, hi.value};
        end else begin
          result.first.out_byte = {hi.value, lo.value};
        end
      end
      default: begin
        if (item.in_byte == CH_PERCENT && !item.in_last) begin
          phase_next = PH_PCT;
        end else begin
          result.count = 2'd1;
          result.first.out_byte = plain_byte(item.in_byte);
          result.first.out_last = item.in_last;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/upd_queue.sv
// small result queue: takes up to two results per cycle, gives one per cycle unless the output is stalled
// depends on upd_pkg
`default_nettype none

module upd_queue (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       push,
  input  wire upd_pkg::dec_result_t result,
  output logic                      room,
  output logic                      valid,
  input  wire                       stall,
  output upd_pkg::dec_item_t        item
);
  import upd_pkg::*;

  dec_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_1;
  logic [QCNT_W-1:0] count, count_next;
  logic [1:0]        n_push;
  logic              pop;

  assign n_push   = push ? result.count : 2'd0;
  assign pop      = valid && !stall;
  assign valid    = (count != '0);
  assign item     = mem[rd_ptr];
  assign wr_ptr_1 = wr_ptr + 1'b1;
  // room for the largest burst of one transaction
  assign room     = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    count_next = count + QCNT_W'(n_push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= result.first;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_1] <= result.second;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/url_percent_decoder.sv
// top level of the url percent decoder
// depends on upd_pkg, upd_decode and upd_queue
`default_nettype none

// Decodes a url-encoded byte stream, one encoded byte per transaction on the
// enc channel, into decoded bytes on the dec channel. '+' becomes a space,
// '%' with two following bytes of the same string becomes one byte from
// those hex digits (only 0-9 and A-F count; conversion stops at the first
// bad digit), and a '%' cut short by the end of the string is passed raw.
// The escape state is updated in the same cycle a byte is accepted, and its
// results go into a four-entry queue that feeds the dec channel directly.
// Rate: one encoded byte per clock while the queue has room for two results;
// a byte yields zero, one or two decoded bytes, and the dec channel gives at
// most one per clock, so sustained throughput is set by that single output
// port. enc_stall rises when the queue holds more than two results.
// Decoded results are written into the queue registers, which drive dec_valid.

module url_percent_decoder (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     enc_valid,
  output logic                    enc_stall,
  input  wire upd_pkg::enc_item_t enc_item,
  output logic                    dec_valid,
  input  wire                     dec_stall,
  output upd_pkg::dec_item_t      dec_item
);
  import upd_pkg::*;

  logic        accept;
  logic        room;
  dec_result_t result;

  // transaction accepted when the queue can take a full burst
  assign enc_stall = !room;
  assign accept    = enc_valid && room;

  // escape state machine and byte decode
  upd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (enc_item),
    .result (result)
  );

  // result queue in front of the output channel
  upd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .result (result),
    .room   (room),
    .valid  (dec_valid),
    .stall  (dec_stall),
    .item   (dec_item)
  );

endmodule

`default_nettype wire

### test/tb_url_percent_decoder.sv
// self-checking testbench for url_percent_decoder: directed table, then random encoded strings
// depends on upd_pkg and the url_percent_decoder rtl
`timescale 1ns / 100ps

module tb_url_percent_decoder;
  import upd_pkg::*;

  // a typed row count of this value means the predictor supplies the expectation
  localparam int PREDICT      = -1;
  localparam int DIR_N        = 24;
  localparam int RANDOM_ITEMS = 1680;
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 64;
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_REPORTS  = 10;

  // one encoded byte plus, optionally, the decoded bytes it must produce
  typedef struct {
    logic [7:0] b;
    logic       l;
    int         n;
    logic [7:0] b0;
    logic       l0;
    logic [7:0] b1;
    logic       l1;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       enc_valid;
  logic       enc_stall;
  enc_item_t  enc_item;
  logic       dec_valid;
  logic       dec_stall;
  dec_item_t  dec_item;

  // predictor state, mirrors the escape tracking of the decoder
  phase_t     esc_phase  = PH_IDLE;
  logic [7:0] held_digit = '0;

  dec_item_t  dec_expected[$];
  int         sent_count  = 0;
  int         string_count = 0;
  int         dec_seen    = 0;
  int         fail_count  = 0;
  logic       calm;
  logic       hold_req;

  // directed transactions, walked in order right after reset
  dir_row_t directed [DIR_N] = '{
    '{8'h41,      1'b0, 1,       8'h41,      1'b0, 8'h00,      1'b0}, // plain 'A'
    '{8'h00,      1'b0, 1,       8'h00,      1'b0, 8'h00,      1'b0}, // lowest byte
    '{8'hFF,      1'b1, 1,       8'hFF,      1'b1, 8'h00,      1'b0}, // highest byte, end
    '{CH_PLUS,    1'b1, 1,       CH_SPACE,   1'b1, 8'h00,      1'b0}, // plus to space
    '{CH_PERCENT, 1'b0, 0,       8'h00,      1'b0, 8'h00,      1'b0}, // escape "%9A"
    '{8'h39,      1'b0, 0,       8'h00,      1'b0, 8'h00,      1'b0},
    '{8'h41,      1'b1, 1,       8'h9A,      1'b1, 8'h00,      1'b0},
    '{CH_PERCENT, 1'b0, PREDICT, 8'h00,      1'b0, 8'h00,      1'b0}, // escape "%FF"
    '{8'h46,      1'b0, PREDICT, 8'h00,      1'b0, 8'h00,      1'b0},
    '{8'h46,      1'b0, PREDICT, 8'h00,      1'b0, 8'h00,      1'b0},
    '{CH_PERCENT, 1'b0, 0,       8'h00,      1'b0, 8'h00,      1'b0}, // lowercase first digit
    '{8'h61,      1'b0, 0,       8'h00,      1'b0, 8'h00,      1'b0},
    '{8'h31,      1'b0, 1,       8'h00,      1'b0, 8'h00,      1'b0},
    '{CH_PERCENT, 1'b0, 0,       8'h00,      1'b0, 8'h00,      1'b0}, // bad second digit
    '{8'h43,      1'b0, 0,       8'h00,      1'b0, 8'h00,      1'b0},
    '{8'h67,      1'b1, 1,       8'h0C,      1'b1, 8'h00,      1'b0},
    '{CH_PERCENT, 1'b1, 1,       CH_PERCENT, 1'b1, 8'h00,      1'b0}, // percent ends string
    '{CH_PERCENT, 1'b0, 0,       8'h00,      1'b0, 8'h00,      1'b0}, // one byte after percent
    '{CH_PLUS,    1'b1, 2,       CH_PERCENT, 1'b0, CH_SPACE,   1'b1},
    '{CH_PERCENT, 1'b0, 0,       8'h00,      1'b0, 8'h00,      1'b0}, // same, that byte a percent
    '{CH_PERCENT, 1'b1, 2,       CH_PERCENT, 1'b0, CH_PERCENT, 1'b1},
    '{CH_PERCENT, 1'b0, PREDICT, 8'h00,      1'b0, 8'h00,      1'b0}, // percent and plus as digits
    '{CH_PERCENT, 1'b0, PREDICT, 8'h00,      1'b0, 8'h00,      1'b0},
    '{CH_PLUS,    1'b0, PREDICT, 8'h00,      1'b0, 8'h00,      1'b0}
  };

  url_percent_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (enc_valid),
    .enc_stall (enc_stall),
    .enc_item  (enc_item),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec_item  (dec_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // {valid, value} of an uppercase hex digit; anything else is not a digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = c - CH_UPPER_A + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // mostly a legal digit, sometimes any byte (lowercase and junk included)
  function automatic logic [7:0] hex_or_junk();
    int idx;
    idx = $urandom_range(0, 15);
    if ($urandom_range(0, 99) >= 85)
      return 8'($urandom_range(0, 255));
    return (idx < 10) ? CH_ZERO + 8'(idx) : CH_UPPER_A + 8'(idx - 10);
  endfunction

  // advances the predictor by one encoded byte and gives the decoded bytes it causes
  task automatic decode_byte(input logic [7:0] b, input logic l,
                             output int n, output dec_item_t r0, output dec_item_t r1);
    logic [4:0] hi;
    logic [4:0] lo;
    r0 = '0;
    r1 = '0;
    n  = 0;
    case (esc_phase)
      PH_PCT: begin
        if (l) begin
          // string ends one byte after the percent: the percent goes out raw, then the byte as ordinary
          r0 = '{CH_PERCENT, 1'b0};
          r1 = '{(b == CH_PLUS) ? CH_SPACE : b, 1'b1};
          n = 2;
          esc_phase = PH_IDLE;
        end else begin
          held_digit = b;
          esc_phase = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        hi = hex_digit(held_digit);
        lo = hex_digit(b);
        // conversion stops at the first bad digit
        if (!hi[4])
          r0.out_byte = 8'h00;
        else if (!lo[4])
          r0.out_byte = {4'h0, hi[3:0]};
        else
          r0.out_byte = {hi[3:0], lo[3:0]};
        r0.out_last = l;
        n = 1;
        esc_phase = PH_IDLE;
      end
      default: begin
        esc_phase = PH_IDLE;
        if (b == CH_PERCENT && !l) begin
          esc_phase = PH_PCT;
        end else begin
          r0 = '{(b == CH_PLUS) ? CH_SPACE : b, l};
          n = 1;
        end
      end
    endcase
  endtask

  // offers one transaction, waits for the handshake, then records what it must produce
  task automatic offer(input dir_row_t r);
    int gap;
    int pn;
    dec_item_t p0;
    dec_item_t p1;
    calm <= (sent_count >= 400 && sent_count < 900);
    hold_req <= (sent_count >= 1100);
    if (!calm && $urandom_range(0, 99) < 11) begin
      enc_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    enc_valid <= 1'b1;
    enc_item  <= '{r.b, r.l};
    @(posedge clk);
    while (enc_stall) @(posedge clk);
    // accepted at this edge
    decode_byte(r.b, r.l, pn, p0, p1);
    if (r.n != PREDICT) begin
      pn = r.n;
      p0 = '{r.b0, r.l0};
      p1 = '{r.b1, r.l1};
    end
    if (pn > 0) dec_expected.push_back(p0);
    if (pn > 1) dec_expected.push_back(p1);
    sent_count++;
  endtask

  // sender: directed table, then random strings, mostly well formed
  initial begin : enc_side
    logic [7:0] str[$];
    dir_row_t   r;
    int         k;
    int         len;
    int         kind;
    rst       = 1'b1;
    enc_valid = 1'b0;
    enc_item  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_N; k++)
      offer(directed[k]);

    while (sent_count < DIR_N + RANDOM_ITEMS) begin
      str.delete();
      if ($urandom_range(0, 99) < 15) begin
        // noise: raw bytes with no structure
        len = $urandom_range(1, 8);
        repeat (len) str.push_back(8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 12);
        while (str.size() < len) begin
          kind = $urandom_range(0, 99);
          if (kind < 45) begin
            str.push_back(8'($urandom_range(0, 255)));
          end else if (kind < 55) begin
            str.push_back(CH_PLUS);
          end else if (kind < 88) begin
            str.push_back(CH_PERCENT);
            str.push_back(hex_or_junk());
            str.push_back(hex_or_junk());
          end else begin
            // lone percent: either cut by the string end or swallows what follows
            str.push_back(CH_PERCENT);
          end
        end
      end
      for (k = 0; k < str.size(); k++) begin
        r = '{str[k], k == str.size() - 1, PREDICT, 8'h00, 1'b0, 8'h00, 1'b0};
        offer(r);
      end
      string_count++;
    end
    enc_valid <= 1'b0;

    // drain, then give the pipeline time to show any stray transaction
    while (dec_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d encoded bytes (%0d random strings), checked %0d decoded bytes",
             sent_count, string_count, dec_seen);
    $display("escapes valid, invalid and cut short, one long output hold; %0d mismatches",
             fail_count);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // receiver: random stalls, a quiet stretch, and one long hold that backs up the input
  initial begin : dec_side
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    dec_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        dec_stall <= 1'b1;
        hold_left--;
      end else begin
        dec_stall <= !calm && ($urandom_range(0, 99) < 11);
      end
    end
  end

  // compare each decoded transaction with the oldest expectation
  always @(posedge clk) begin : dec_check
    dec_item_t want;
    if (!rst && dec_valid && !dec_stall) begin
      dec_seen++;
      if (dec_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected decoded byte %02h last %0b", dec_item.out_byte,
                   dec_item.out_last);
      end else begin
        want = dec_expected.pop_front();
        if (want.out_byte !== dec_item.out_byte || want.out_last !== dec_item.out_last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("decoded byte %0d: expected %02h last %0b, got %02h last %0b",
                     dec_seen, want.out_byte, want.out_last,
                     dec_item.out_byte, dec_item.out_last);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin : hang_watch
    int idle_cycles;
    if (rst || (enc_valid && !enc_stall) || (dec_valid && !dec_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

### url_percent_decoder.f
hw/rtl/upd_pkg.sv
hw/rtl/upd_decode.sv
hw/rtl/upd_queue.sv
hw/rtl/url_percent_decoder.sv
test/tb_url_percent_decoder.sv
